### sv/motor_link_battery_guard_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor link battery guard
// Property wrappers for the checks at the end of the guard RTL module.
// ----------------------------------------------------------------------------
`ifndef MOTOR_LINK_BATTERY_GUARD_UNIT_MACROS_SVH
`define MOTOR_LINK_BATTERY_GUARD_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define MLBG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mlbg assertion failed");
// Next-cycle implication, disabled while reset is low
`define MLBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mlbg assertion failed");
`else
`define MLBG_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MLBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/mlbg_pkg.sv
// ----------------------------------------------------------------------------
// Motor link battery guard package
// Shared widths, reset values, register indexes and codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mlbg_pkg;

    localparam int SAMPLES_PER_READING_DEF = 5;
    localparam int FRAME_BYTES_DEF         = 8;

    localparam int NUM_W   = 25;  // drive numerator
    localparam int SUM_W   = 15;  // battery sum and levels
    localparam int LVL_W   = 16;  // compare values
    localparam int TICK_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int ADC_W   = 12;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 25;

    localparam int DIR_INDEX_M1 = 4;
    localparam int DIR_INDEX_M2 = 6;

    localparam logic [BYTE_W-1:0] DIR_FWD  = 8'd0;
    localparam logic [BYTE_W-1:0] DIR_STOP = 8'd1;
    localparam logic [BYTE_W-1:0] DIR_REV  = 8'd2;

    // register indexes on the configuration port
    localparam logic [CIDX_W-1:0] CFG_PWM_TOP   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_NUMERATOR = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_CUTOFF    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_RESUME    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_FLOOR     = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_TIMEOUT   = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_SYNC      = 3'd6;

    localparam logic [LVL_W-1:0]  PWM_TOP_RST   = 16'd1561;
    localparam logic [NUM_W-1:0]  NUMERATOR_RST = 25'd20811385;
    localparam logic [SUM_W-1:0]  CUTOFF_RST    = 15'd12512;
    localparam logic [SUM_W-1:0]  RESUME_RST    = 15'd13332;
    localparam logic [SUM_W-1:0]  FLOOR_RST     = 15'd1026;
    localparam logic [TICK_W-1:0] TIMEOUT_RST   = 16'd2000;
    localparam logic [BYTE_W-1:0] SYNC_RST      = 8'hFF;

    localparam logic [SUM_W-1:0]  SUM_MAX  = 15'h7FFF;
    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_TICK   = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

### sv/mlbg_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle, for the drive level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlbg_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [mlbg_pkg::NUM_W-1:0] dividend,
    input  wire logic [mlbg_pkg::SUM_W-1:0] divisor,
    output logic                            done,
    output logic [mlbg_pkg::NUM_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(mlbg_pkg::NUM_W);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [mlbg_pkg::SUM_W-1:0] rem_reg, rem_next;
    logic [mlbg_pkg::SUM_W-1:0] dvs_reg, dvs_next;
    logic [mlbg_pkg::NUM_W-1:0] quo_reg, quo_next;
    logic [mlbg_pkg::SUM_W:0]   rem_shift;
    logic [mlbg_pkg::SUM_W:0]   rem_diff;

    assign rem_shift = {rem_reg, quo_reg[mlbg_pkg::NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(mlbg_pkg::NUM_W - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract when it fits
            if (rem_shift >= {1'b0, dvs_reg}) begin
                rem_next = rem_diff[mlbg_pkg::SUM_W-1:0];
                quo_next = {quo_reg[mlbg_pkg::NUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[mlbg_pkg::SUM_W-1:0];
                quo_next = {quo_reg[mlbg_pkg::NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### sv/motor_link_battery_guard_unit.sv
// ----------------------------------------------------------------------------
// Motor link battery guard
// Command frame receiver, battery hysteresis guard and drive level for two
// motors, with a link timeout.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A serial byte, a tick or a
// battery sample that does not close a reading passes through the apply and
// emit states to a result in the output register. A sample that closes a
// reading runs the serial divider for the drive level, one quotient bit
// per cycle over 25 bits, before the emit state. The input is not ready while an
// item is in flight and comes back in the cycle after the result is
// registered, so a new transaction is taken only once the last one is done; a
// finished result waits in the output register while the next transaction is
// accepted. Configuration writes land at once.
`default_nettype none
`include "motor_link_battery_guard_unit_macros.svh"

module motor_link_battery_guard_unit #(
    parameter int SAMPLES_PER_READING = mlbg_pkg::SAMPLES_PER_READING_DEF,
    parameter int FRAME_BYTES         = mlbg_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_we,
    input  wire logic [mlbg_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [mlbg_pkg::CDATA_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [23:0]                  s_tdata,  // rx_byte, adc_sample
    input  wire logic [1:0]                   s_tuser,  // opcode
    // result stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // motor1_fwd_cmp, motor1_rev_cmp, motor2_fwd_cmp, motor2_rev_cmp,
    // safe_now, link_lost, frame_done
    output logic [71:0]                       m_tdata
);

    localparam int CNT_W  = $clog2(SAMPLES_PER_READING + 1);
    localparam int FIDX_W = $clog2(FRAME_BYTES + 1);

    // configuration registers
    logic [mlbg_pkg::LVL_W-1:0]  pwm_top_reg;
    logic [mlbg_pkg::NUM_W-1:0]  numerator_reg;
    logic [mlbg_pkg::SUM_W-1:0]  cutoff_reg;
    logic [mlbg_pkg::SUM_W-1:0]  resume_reg;
    logic [mlbg_pkg::SUM_W-1:0]  floor_reg;
    logic [mlbg_pkg::TICK_W-1:0] timeout_reg;
    logic [mlbg_pkg::BYTE_W-1:0] sync_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_top_reg   <= mlbg_pkg::PWM_TOP_RST;
            numerator_reg <= mlbg_pkg::NUMERATOR_RST;
            cutoff_reg    <= mlbg_pkg::CUTOFF_RST;
            resume_reg    <= mlbg_pkg::RESUME_RST;
            floor_reg     <= mlbg_pkg::FLOOR_RST;
            timeout_reg   <= mlbg_pkg::TIMEOUT_RST;
            sync_reg      <= mlbg_pkg::SYNC_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                mlbg_pkg::CFG_PWM_TOP:   pwm_top_reg   <= cfg_wdata[mlbg_pkg::LVL_W-1:0];
                mlbg_pkg::CFG_NUMERATOR: numerator_reg <= cfg_wdata[mlbg_pkg::NUM_W-1:0];
                mlbg_pkg::CFG_CUTOFF:    cutoff_reg    <= cfg_wdata[mlbg_pkg::SUM_W-1:0];
                mlbg_pkg::CFG_RESUME:    resume_reg    <= cfg_wdata[mlbg_pkg::SUM_W-1:0];
                mlbg_pkg::CFG_FLOOR:     floor_reg     <= cfg_wdata[mlbg_pkg::SUM_W-1:0];
                mlbg_pkg::CFG_TIMEOUT:   timeout_reg   <= cfg_wdata[mlbg_pkg::TICK_W-1:0];
                mlbg_pkg::CFG_SYNC:      sync_reg      <= cfg_wdata[mlbg_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and block state
    mlbg_pkg::state_t            state_reg, state_next;
    logic [1:0]                  op_reg, op_next;
    logic [mlbg_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic [mlbg_pkg::ADC_W-1:0]  sample_reg, sample_next;
    logic [FIDX_W-1:0]           fidx_reg, fidx_next;
    logic [mlbg_pkg::BYTE_W-1:0] m1_pend_reg, m1_pend_next;
    logic [mlbg_pkg::BYTE_W-1:0] m2_pend_reg, m2_pend_next;
    logic [mlbg_pkg::BYTE_W-1:0] m1_dir_reg, m1_dir_next;
    logic [mlbg_pkg::BYTE_W-1:0] m2_dir_reg, m2_dir_next;
    logic                        safe_reg, safe_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [mlbg_pkg::SUM_W-1:0]  acc_reg, acc_next;
    logic [mlbg_pkg::SUM_W-1:0]  bsum_reg, bsum_next;
    logic [mlbg_pkg::LVL_W-1:0]  drive_reg, drive_next;
    logic [mlbg_pkg::TICK_W-1:0] ticks_reg, ticks_next;
    logic                        fdone_reg, fdone_next;
    logic                        m_valid_reg, m_valid_next;
    logic [71:0]                 m_data_reg, m_data_next;

    logic                        div_start;
    logic                        div_done;
    logic [mlbg_pkg::NUM_W-1:0]  div_quo;

    logic [mlbg_pkg::SUM_W:0]    acc_sum;
    logic [mlbg_pkg::SUM_W-1:0]  acc_sat;
    logic [CNT_W-1:0]            cnt_inc;
    logic [mlbg_pkg::SUM_W-1:0]  floor_eff;
    logic [mlbg_pkg::SUM_W-1:0]  sum_floored;
    logic                        finish_now;
    logic                        lost;
    logic [mlbg_pkg::BYTE_W-1:0] m1_eff, m2_eff;
    logic [mlbg_pkg::LVL_W-1:0]  level;
    logic [mlbg_pkg::LVL_W-1:0]  m1_fwd, m1_rev, m2_fwd, m2_rev;

    assign acc_sum     = {1'b0, acc_reg} + {{(mlbg_pkg::SUM_W + 1 - mlbg_pkg::ADC_W){1'b0}},
                                            sample_reg};
    assign acc_sat     = acc_sum[mlbg_pkg::SUM_W] ? mlbg_pkg::SUM_MAX
                                                  : acc_sum[mlbg_pkg::SUM_W-1:0];
    assign cnt_inc     = cnt_reg + 1'b1;
    assign floor_eff   = (floor_reg == '0) ? mlbg_pkg::SUM_W'(1) : floor_reg;
    assign sum_floored = (acc_sat < floor_eff) ? floor_eff : acc_sat;
    assign finish_now  = (mlbg_pkg::opcode_t'(op_reg) == mlbg_pkg::OP_SAMPLE)
                         && (cnt_inc == CNT_W'(SAMPLES_PER_READING));

    // result view of the state after the item, timeout stop applied
    assign lost   = ticks_reg > timeout_reg;
    assign m1_eff = lost ? mlbg_pkg::DIR_STOP : m1_dir_reg;
    assign m2_eff = lost ? mlbg_pkg::DIR_STOP : m2_dir_reg;
    assign level  = (drive_reg < pwm_top_reg) ? drive_reg : pwm_top_reg;
    assign m1_fwd = (safe_reg && m1_eff == mlbg_pkg::DIR_FWD) ? level : '0;
    assign m1_rev = (safe_reg && m1_eff == mlbg_pkg::DIR_REV) ? level : '0;
    assign m2_fwd = (safe_reg && m2_eff == mlbg_pkg::DIR_FWD) ? level : '0;
    assign m2_rev = (safe_reg && m2_eff == mlbg_pkg::DIR_REV) ? level : '0;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        byte_next    = byte_reg;
        sample_next  = sample_reg;
        fidx_next    = fidx_reg;
        m1_pend_next = m1_pend_reg;
        m2_pend_next = m2_pend_reg;
        m1_dir_next  = m1_dir_reg;
        m2_dir_next  = m2_dir_reg;
        safe_next    = safe_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        bsum_next    = bsum_reg;
        drive_next   = drive_reg;
        ticks_next   = ticks_reg;
        fdone_next   = fdone_reg;
        m_valid_next = (m_valid_reg && m_tready) ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        s_tready     = 1'b0;

        case (state_reg)
            mlbg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    byte_next   = s_tdata[7:0];
                    sample_next = s_tdata[19:8];
                    state_next  = mlbg_pkg::ST_APPLY;
                end
            end
            mlbg_pkg::ST_APPLY: begin
                fdone_next = 1'b0;
                state_next = mlbg_pkg::ST_EMIT;
                case (mlbg_pkg::opcode_t'(op_reg))
                    mlbg_pkg::OP_BYTE: begin
                        if (fidx_reg == '0) begin
                            if (safe_reg && byte_reg == sync_reg) begin
                                fidx_next = FIDX_W'(1);
                            end
                        end else begin
                            if (fidx_reg == FIDX_W'(mlbg_pkg::DIR_INDEX_M1 + 1)) begin
                                m1_pend_next = byte_reg;
                            end
                            if (fidx_reg == FIDX_W'(mlbg_pkg::DIR_INDEX_M2 + 1)) begin
                                m2_pend_next = byte_reg;
                            end
                            if (fidx_reg == FIDX_W'(FRAME_BYTES)) begin
                                // last byte: commit the directions
                                m1_dir_next = m1_pend_reg;
                                m2_dir_next = m2_pend_reg;
                                ticks_next  = '0;
                                fidx_next   = '0;
                                fdone_next  = 1'b1;
                            end else begin
                                fidx_next = fidx_reg + 1'b1;
                            end
                        end
                    end
                    mlbg_pkg::OP_SAMPLE: begin
                        if (finish_now) begin
                            bsum_next = sum_floored;
                            if (sum_floored < cutoff_reg) begin
                                safe_next   = 1'b0;
                                m1_dir_next = mlbg_pkg::DIR_STOP;
                                m2_dir_next = mlbg_pkg::DIR_STOP;
                            end else if (sum_floored > resume_reg) begin
                                safe_next = 1'b1;
                            end
                            cnt_next   = '0;
                            acc_next   = '0;
                            state_next = mlbg_pkg::ST_DIV_START;
                        end else begin
                            cnt_next = cnt_inc;
                            acc_next = acc_sat;
                        end
                    end
                    mlbg_pkg::OP_TICK: begin
                        if (ticks_reg != mlbg_pkg::TICK_MAX) begin
                            ticks_next = ticks_reg + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            mlbg_pkg::ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = mlbg_pkg::ST_DIV_WAIT;
            end
            mlbg_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    // cap at the top compare value
                    drive_next = (div_quo > {{(mlbg_pkg::NUM_W - mlbg_pkg::LVL_W){1'b0}},
                                             pwm_top_reg})
                                 ? pwm_top_reg : div_quo[mlbg_pkg::LVL_W-1:0];
                    state_next = mlbg_pkg::ST_EMIT;
                end
            end
            mlbg_pkg::ST_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m1_dir_next  = m1_eff;
                    m2_dir_next  = m2_eff;
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, fdone_reg, lost, safe_reg,
                                    m2_rev, m2_fwd, m1_rev, m1_fwd};
                    state_next   = mlbg_pkg::ST_IDLE;
                end
            end
            default: state_next = mlbg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mlbg_pkg::ST_IDLE;
            fidx_reg    <= '0;
            m1_dir_reg  <= mlbg_pkg::DIR_STOP;
            m2_dir_reg  <= mlbg_pkg::DIR_STOP;
            safe_reg    <= 1'b1;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            bsum_reg    <= mlbg_pkg::FLOOR_RST;
            drive_reg   <= mlbg_pkg::PWM_TOP_RST;
            ticks_reg   <= '0;
            fdone_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fidx_reg    <= fidx_next;
            m1_dir_reg  <= m1_dir_next;
            m2_dir_reg  <= m2_dir_next;
            safe_reg    <= safe_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            bsum_reg    <= bsum_next;
            drive_reg   <= drive_next;
            ticks_reg   <= ticks_next;
            fdone_reg   <= fdone_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg      <= op_next;
        byte_reg    <= byte_next;
        sample_reg  <= sample_next;
        m1_pend_reg <= m1_pend_next;
        m2_pend_reg <= m2_pend_next;
        m_data_reg  <= m_data_next;
    end

    mlbg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (numerator_reg),
        .divisor  (bsum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `MLBG_ASSERT_NOW(a_div_done_in_wait, aclk, aresetn,
        div_done, state_reg == mlbg_pkg::ST_DIV_WAIT)
    `MLBG_ASSERT_NOW(a_unsafe_outputs_zero, aclk, aresetn,
        m_valid_reg && !m_data_reg[64], m_data_reg[63:0] == 64'd0)
    `MLBG_ASSERT_NOW(a_frame_clears_loss, aclk, aresetn,
        m_valid_reg && m_data_reg[66], !m_data_reg[65])
    `MLBG_ASSERT_NEXT(a_output_drains, aclk, aresetn,
        m_valid_reg && m_tready && state_reg != mlbg_pkg::ST_EMIT, !m_valid_reg)

endmodule

`default_nettype wire

### test/tb_motor_link_battery_guard_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the motor link battery guard
// Drives serial bytes, battery samples and millisecond ticks into the block,
// predicts every result transaction with a behavioral guard model kept in
// step with the configuration writes, and checks each result field by field.
// Both stream sides idle and stall at random; one test holds the result side
// off for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_motor_link_battery_guard_unit;

    localparam logic [1:0]                  OP_NONE      = 2'd3;
    localparam logic [mlbg_pkg::CIDX_W-1:0] CFG_UNUSED   = 3'd7;
    localparam int                          MAX_GAP      = 18;
    localparam int                          DRAIN_CYCLES = 40;
    localparam int                          MAX_REPORTS  = 10;
    localparam int                          HOLD_CYCLES  = 400;
    localparam int                          ADC_MAX      = 4095;

    // result layout, lowest bit last
    typedef struct packed {
        logic [4:0]                 pad;
        logic                       frame_done;
        logic                       link_lost;
        logic                       safe_now;
        logic [mlbg_pkg::LVL_W-1:0] m2_rev;
        logic [mlbg_pkg::LVL_W-1:0] m2_fwd;
        logic [mlbg_pkg::LVL_W-1:0] m1_rev;
        logic [mlbg_pkg::LVL_W-1:0] m1_fwd;
    } guard_result_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [mlbg_pkg::CIDX_W-1:0]  cfg_index = '0;
    logic [mlbg_pkg::CDATA_W-1:0] cfg_wdata = '0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [23:0]                  s_tdata   = '0;  // rx_byte, adc_sample
    logic [1:0]                   s_tuser   = '0;  // opcode
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    // motor1_fwd_cmp, motor1_rev_cmp, motor2_fwd_cmp, motor2_rev_cmp,
    // safe_now, link_lost, frame_done
    logic [71:0]                  m_tdata;

    motor_link_battery_guard_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    // guard model: configuration
    logic [mlbg_pkg::LVL_W-1:0]  pwm_top_r   = mlbg_pkg::PWM_TOP_RST;
    logic [mlbg_pkg::NUM_W-1:0]  numerator_r = mlbg_pkg::NUMERATOR_RST;
    logic [mlbg_pkg::SUM_W-1:0]  cutoff_r    = mlbg_pkg::CUTOFF_RST;
    logic [mlbg_pkg::SUM_W-1:0]  resume_r    = mlbg_pkg::RESUME_RST;
    logic [mlbg_pkg::SUM_W-1:0]  floor_r     = mlbg_pkg::FLOOR_RST;
    logic [mlbg_pkg::TICK_W-1:0] timeout_r   = mlbg_pkg::TIMEOUT_RST;
    logic [mlbg_pkg::BYTE_W-1:0] sync_r      = mlbg_pkg::SYNC_RST;

    // guard model: state
    int unsigned                 frame_pos   = 0;
    logic [mlbg_pkg::BYTE_W-1:0] frame_bytes [mlbg_pkg::FRAME_BYTES_DEF];
    logic [mlbg_pkg::BYTE_W-1:0] m1_dir      = mlbg_pkg::DIR_STOP;
    logic [mlbg_pkg::BYTE_W-1:0] m2_dir      = mlbg_pkg::DIR_STOP;
    logic                        safe_bit    = 1'b1;
    int unsigned                 sample_cnt  = 0;
    int unsigned                 sample_acc  = 0;
    int unsigned                 drive_lvl   = mlbg_pkg::PWM_TOP_RST;
    int unsigned                 tick_count  = 0;

    guard_result_t expected_results[$];
    int            error_count   = 0;
    int            result_count  = 0;
    bit            idle_enable   = 1'b1;
    int            hold_cycles   = 0;

    function automatic guard_result_t guard_step(input logic [1:0] op,
                                                 input logic [7:0] rx,
                                                 input logic [11:0] adc);
        guard_result_t r;
        int unsigned   lo;
        int unsigned   sum;
        int unsigned   lvl;
        logic          done;
        done = 1'b0;
        case (op)
            mlbg_pkg::OP_BYTE: begin
                if (frame_pos == 0) begin
                    if (safe_bit && rx == sync_r)
                        frame_pos = 1;
                end else begin
                    frame_bytes[frame_pos - 1] = rx;
                    if (frame_pos >= mlbg_pkg::FRAME_BYTES_DEF) begin
                        m1_dir     = frame_bytes[mlbg_pkg::DIR_INDEX_M1];
                        m2_dir     = frame_bytes[mlbg_pkg::DIR_INDEX_M2];
                        tick_count = 0;
                        frame_pos  = 0;
                        done       = 1'b1;
                    end else begin
                        frame_pos++;
                    end
                end
            end
            mlbg_pkg::OP_SAMPLE: begin
                sample_acc += adc;
                if (sample_acc > mlbg_pkg::SUM_MAX)
                    sample_acc = mlbg_pkg::SUM_MAX;
                sample_cnt++;
                if (sample_cnt >= mlbg_pkg::SAMPLES_PER_READING_DEF) begin
                    lo  = (floor_r == 0) ? 1 : floor_r;
                    sum = (sample_acc < lo) ? lo : sample_acc;
                    if (sum < cutoff_r) begin
                        safe_bit = 1'b0;
                        m1_dir   = mlbg_pkg::DIR_STOP;
                        m2_dir   = mlbg_pkg::DIR_STOP;
                    end else if (sum > resume_r) begin
                        safe_bit = 1'b1;
                    end
                    drive_lvl = numerator_r / sum;
                    if (drive_lvl > pwm_top_r)
                        drive_lvl = pwm_top_r;
                    sample_cnt = 0;
                    sample_acc = 0;
                end
            end
            mlbg_pkg::OP_TICK: begin
                if (tick_count < mlbg_pkg::TICK_MAX)
                    tick_count++;
            end
            default: ;
        endcase

        if (tick_count > timeout_r) begin
            m1_dir = mlbg_pkg::DIR_STOP;
            m2_dir = mlbg_pkg::DIR_STOP;
        end

        lvl          = (drive_lvl < pwm_top_r) ? drive_lvl : pwm_top_r;
        r            = '0;
        r.m1_fwd     = (safe_bit && m1_dir == mlbg_pkg::DIR_FWD) ? lvl[15:0] : '0;
        r.m1_rev     = (safe_bit && m1_dir == mlbg_pkg::DIR_REV) ? lvl[15:0] : '0;
        r.m2_fwd     = (safe_bit && m2_dir == mlbg_pkg::DIR_FWD) ? lvl[15:0] : '0;
        r.m2_rev     = (safe_bit && m2_dir == mlbg_pkg::DIR_REV) ? lvl[15:0] : '0;
        r.safe_now   = safe_bit;
        r.link_lost  = (tick_count > timeout_r);
        r.frame_done = done;
        return r;
    endfunction

    task automatic write_reg(input logic [mlbg_pkg::CIDX_W-1:0] idx,
                             input logic [mlbg_pkg::CDATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            mlbg_pkg::CFG_PWM_TOP:   pwm_top_r   = value[mlbg_pkg::LVL_W-1:0];
            mlbg_pkg::CFG_NUMERATOR: numerator_r = value[mlbg_pkg::NUM_W-1:0];
            mlbg_pkg::CFG_CUTOFF:    cutoff_r    = value[mlbg_pkg::SUM_W-1:0];
            mlbg_pkg::CFG_RESUME:    resume_r    = value[mlbg_pkg::SUM_W-1:0];
            mlbg_pkg::CFG_FLOOR:     floor_r     = value[mlbg_pkg::SUM_W-1:0];
            mlbg_pkg::CFG_TIMEOUT:   timeout_r   = value[mlbg_pkg::TICK_W-1:0];
            mlbg_pkg::CFG_SYNC:      sync_r      = value[mlbg_pkg::BYTE_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [15:0] pwm, input logic [24:0] num,
                               input logic [14:0] cut, input logic [14:0] res,
                               input logic [14:0] flr, input logic [15:0] tmo,
                               input logic [7:0] sync);
        write_reg(mlbg_pkg::CFG_PWM_TOP, 25'(pwm));
        write_reg(mlbg_pkg::CFG_NUMERATOR, num);
        write_reg(mlbg_pkg::CFG_CUTOFF, 25'(cut));
        write_reg(mlbg_pkg::CFG_RESUME, 25'(res));
        write_reg(mlbg_pkg::CFG_FLOOR, 25'(flr));
        write_reg(mlbg_pkg::CFG_TIMEOUT, 25'(tmo));
        write_reg(mlbg_pkg::CFG_SYNC, 25'(sync));
    endtask

    // Keep valid high across back-to-back transactions; lower it only for a gap.
    task automatic send_item(input logic [1:0] op, input logic [7:0] rx,
                             input logic [11:0] adc);
        int gap;
        gap = idle_enable ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, adc, rx};
        do @(posedge aclk); while (s_tready !== 1'b1);
        expected_results.push_back(guard_step(op, rx, adc));
    endtask

    task automatic wait_idle;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] dir1, input logic [7:0] dir2);
        send_item(mlbg_pkg::OP_BYTE, sync_r, 12'($urandom_range(0, ADC_MAX)));
        for (int i = 0; i < mlbg_pkg::FRAME_BYTES_DEF; i++) begin
            if (i == mlbg_pkg::DIR_INDEX_M1)
                send_item(mlbg_pkg::OP_BYTE, dir1, 12'($urandom_range(0, ADC_MAX)));
            else if (i == mlbg_pkg::DIR_INDEX_M2)
                send_item(mlbg_pkg::OP_BYTE, dir2, 12'($urandom_range(0, ADC_MAX)));
            else
                send_item(mlbg_pkg::OP_BYTE, 8'($urandom_range(0, 255)),
                          12'($urandom_range(0, ADC_MAX)));
        end
    endtask

    task automatic send_reading(input int base, input int spread);
        int s;
        for (int i = 0; i < mlbg_pkg::SAMPLES_PER_READING_DEF; i++) begin
            s = base + int'($urandom_range(0, 2 * spread)) - spread;
            if (s < 0)
                s = 0;
            if (s > ADC_MAX)
                s = ADC_MAX;
            send_item(mlbg_pkg::OP_SAMPLE, 8'($urandom_range(0, 255)), s[11:0]);
        end
    endtask

    function automatic logic [7:0] pick_direction;
        case ($urandom_range(0, 3))
            0:       return mlbg_pkg::DIR_FWD;
            1:       return mlbg_pkg::DIR_REV;
            2:       return mlbg_pkg::DIR_STOP;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly whole frames and whole readings with random content, some noise.
    task automatic random_traffic(input int count);
        int sent;
        int pick;
        int len;
        int base;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 15) == 0)
                idle_enable = ~idle_enable;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_frame(pick_direction(), pick_direction());
                sent += mlbg_pkg::FRAME_BYTES_DEF + 1;
            end else if (pick < 70) begin
                case ($urandom_range(0, 3))
                    0:       base = $urandom_range(0, ADC_MAX);
                    1:       base = cutoff_r / mlbg_pkg::SAMPLES_PER_READING_DEF;
                    2:       base = resume_r / mlbg_pkg::SAMPLES_PER_READING_DEF;
                    default: base = floor_r / mlbg_pkg::SAMPLES_PER_READING_DEF;
                endcase
                send_reading(base, 30);
                sent += mlbg_pkg::SAMPLES_PER_READING_DEF;
            end else if (pick < 85) begin
                len = $urandom_range(1, 8);
                repeat (len) send_item(mlbg_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                                       12'($urandom_range(0, ADC_MAX)));
                sent += len;
            end else begin
                case ($urandom_range(0, 4))
                    0: send_item(mlbg_pkg::OP_BYTE, 8'($urandom_range(0, 255)),
                                 12'($urandom_range(0, ADC_MAX)));
                    1: send_item(mlbg_pkg::OP_SAMPLE, 8'($urandom_range(0, 255)),
                                 12'($urandom_range(0, ADC_MAX)));
                    2: send_item(OP_NONE, 8'($urandom_range(0, 255)),
                                 12'($urandom_range(0, ADC_MAX)));
                    default: begin
                        // broken frame: sync and a few bytes only
                        len = $urandom_range(0, mlbg_pkg::FRAME_BYTES_DEF - 1);
                        send_item(mlbg_pkg::OP_BYTE, sync_r,
                                  12'($urandom_range(0, ADC_MAX)));
                        repeat (len) send_item(mlbg_pkg::OP_BYTE,
                                               8'($urandom_range(0, 255)),
                                               12'($urandom_range(0, ADC_MAX)));
                        sent += len;
                    end
                endcase
                sent++;
            end
        end
        idle_enable = 1'b1;
    endtask

    task automatic test_directed_sequence;
        send_item(mlbg_pkg::OP_BYTE, sync_r, 12'hFFF);
        send_item(mlbg_pkg::OP_BYTE, 8'h00, 12'h000);
        send_item(mlbg_pkg::OP_BYTE, 8'hFF, 12'h000);
        send_item(mlbg_pkg::OP_BYTE, 8'h00, 12'hFFF);
        send_item(mlbg_pkg::OP_BYTE, 8'hFF, 12'h000);
        // battery drops in the middle of the frame
        send_reading(0, 0);
        send_item(mlbg_pkg::OP_BYTE, mlbg_pkg::DIR_FWD, 12'h000);
        send_item(mlbg_pkg::OP_BYTE, 8'h5A, 12'hFFF);
        send_item(mlbg_pkg::OP_BYTE, mlbg_pkg::DIR_REV, 12'h000);
        send_item(mlbg_pkg::OP_BYTE, 8'hA5, 12'h000);
        // sync is dropped while unsafe
        send_item(mlbg_pkg::OP_BYTE, sync_r, 12'h000);
        send_item(OP_NONE, 8'hFF, 12'hFFF);
        send_reading(ADC_MAX, 0);
        send_item(mlbg_pkg::OP_TICK, 8'h00, 12'h000);
        wait_idle();
    endtask

    task automatic test_config_extremes;
        load_config(16'd0, 25'h1FFFFFF, 15'd0, 15'd0, 15'd0, 16'd0, 8'h00);
        random_traffic(60);
        wait_idle();
        load_config(16'hFFFF, 25'd0, 15'd20475, 15'd20475, 15'd20475, 16'hFFFF, 8'hFF);
        random_traffic(60);
        wait_idle();
        load_config(16'hFFFF, 25'h1FFFFFF, 15'd1000, 15'd2000, 15'd1, 16'hFFFF, 8'h80);
        random_traffic(60);
        wait_idle();
    endtask

    task automatic test_link_timeout;
        load_config(mlbg_pkg::PWM_TOP_RST, mlbg_pkg::NUMERATOR_RST, mlbg_pkg::CUTOFF_RST,
                    mlbg_pkg::RESUME_RST, mlbg_pkg::FLOOR_RST, 16'd3, mlbg_pkg::SYNC_RST);
        send_reading(ADC_MAX, 0);
        send_frame(mlbg_pkg::DIR_FWD, mlbg_pkg::DIR_REV);
        repeat (5) send_item(mlbg_pkg::OP_TICK, 8'h00, 12'h000);
        send_frame(mlbg_pkg::DIR_REV, mlbg_pkg::DIR_FWD);
        random_traffic(60);
        wait_idle();
    endtask

    task automatic test_backpressure;
        load_config(mlbg_pkg::PWM_TOP_RST, mlbg_pkg::NUMERATOR_RST, mlbg_pkg::CUTOFF_RST,
                    mlbg_pkg::RESUME_RST, mlbg_pkg::FLOOR_RST, mlbg_pkg::TIMEOUT_RST,
                    mlbg_pkg::SYNC_RST);
        idle_enable = 1'b0;
        hold_cycles = HOLD_CYCLES;
        send_reading(ADC_MAX, 0);
        send_frame(mlbg_pkg::DIR_FWD, mlbg_pkg::DIR_REV);
        repeat (16) send_item(mlbg_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                              12'($urandom_range(0, ADC_MAX)));
        wait_idle();
        idle_enable = 1'b1;
    endtask

    task automatic test_random_settings;
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 0)
                write_reg(CFG_UNUSED, 25'($urandom_range(0, 33554431)));
            write_reg(mlbg_pkg::CFG_PWM_TOP, 25'(($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 33554431) : $urandom_range(200, 2000)));
            write_reg(mlbg_pkg::CFG_NUMERATOR, 25'($urandom_range(0, 33554431)));
            write_reg(mlbg_pkg::CFG_CUTOFF, 25'($urandom_range(0, 20475)));
            write_reg(mlbg_pkg::CFG_RESUME, 25'($urandom_range(0, 20475)));
            write_reg(mlbg_pkg::CFG_FLOOR, 25'(($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 33554431) : $urandom_range(0, 2000)));
            write_reg(mlbg_pkg::CFG_TIMEOUT, 25'($urandom_range(0, 30)));
            write_reg(mlbg_pkg::CFG_SYNC, 25'($urandom_range(0, 255)));
            random_traffic(110);
            wait_idle();
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("result %0d %s: expected %0d, got %0d",
                         result_count, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        guard_result_t got;
        guard_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got = m_tdata;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected: %h",
                             result_count, m_tdata);
            end else begin
                want = expected_results.pop_front();
                compare_field("motor1_fwd_cmp", want.m1_fwd, got.m1_fwd);
                compare_field("motor1_rev_cmp", want.m1_rev, got.m1_rev);
                compare_field("motor2_fwd_cmp", want.m2_fwd, got.m2_fwd);
                compare_field("motor2_rev_cmp", want.m2_rev, got.m2_rev);
                compare_field("safe_now", 16'(want.safe_now), 16'(got.safe_now));
                compare_field("link_lost", 16'(want.link_lost), 16'(got.link_lost));
                compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
                compare_field("padding", 16'(want.pad), 16'(got.pad));
            end
            result_count++;
        end
    end

    // Result side: random stall before each transaction, or a long hold on request.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = idle_enable ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        for (int i = 0; i < mlbg_pkg::FRAME_BYTES_DEF; i++)
            frame_bytes[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_sequence();
        test_config_extremes();
        test_link_timeout();
        test_backpressure();
        test_random_settings();
        wait_idle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
